// File: src/life_grid_stepper_macros.svh
// ----------------------------------------------------------------------------
// Life grid stepper assertion macros
// Shared concurrent assertion forms for the grid stepper RTL.
// ----------------------------------------------------------------------------
`ifndef LIFE_GRID_STEPPER_MACROS_SVH
`define LIFE_GRID_STEPPER_MACROS_SVH

// condition must hold on every clock edge outside reset
`define LGS_ASSERT_HOLD(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define LGS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LGS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/lgs_pkg.sv
// ----------------------------------------------------------------------------
// Life grid stepper package
// Field widths, mode and register codes, rule constants, state and
// window control types shared by the grid stepper modules.
// ----------------------------------------------------------------------------
package lgs_pkg;

   localparam int MODE_W    = 2;
   localparam int ROWF_W    = 7;
   localparam int COLF_W    = 7;
   localparam int CFG_W     = 8;
   localparam int CSR_IDX_W = 2;
   localparam int NBR_CNT_W = 4;

   localparam int NEIGHBOR_COUNT = 8;

   localparam logic [NBR_CNT_W-1:0] SURVIVE_COUNT = 4'd2;
   localparam logic [NBR_CNT_W-1:0] BIRTH_COUNT   = 4'd3;

   localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_STEP  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COLS = 2'd1;

   localparam logic [CFG_W-1:0] RESET_LIMIT = 8'd100;

   typedef enum logic [7:0] {
      S_CLEAR = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_CELL  = 8'b0000_0100,
      S_FETCH = 8'b0000_1000,
      S_SHIFT = 8'b0001_0000,
      S_COLS  = 8'b0010_0000,
      S_WRITE = 8'b0100_0000,
      S_DONE  = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic load_live;
      logic advance;
      logic col_last;
      logic keep;
   } win_ctrl_type;

endpackage

// File: src/lgs_grid_mem.sv
// ----------------------------------------------------------------------------
// Grid row memory
// One row of cells per entry, one write port and one registered read port.
// ----------------------------------------------------------------------------
module lgs_grid_mem #(
   parameter int DEPTH = 128,
   parameter int WIDTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: src/lgs_cell_rule.sv
// ----------------------------------------------------------------------------
// Cell rule unit
// Counts the eight neighbors of one cell and applies the B3/S23 rule.
// ----------------------------------------------------------------------------
module lgs_cell_rule (
   input  logic                                center,
   input  logic [lgs_pkg::NEIGHBOR_COUNT-1:0]  neighbors,
   output logic                                alive
);

   logic [lgs_pkg::NBR_CNT_W-1:0] count;

   always_comb begin
      count = '0;
      for (int i = 0; i < lgs_pkg::NEIGHBOR_COUNT; i++) begin
         count = count + lgs_pkg::NBR_CNT_W'(neighbors[i]);
      end
      alive = (count == lgs_pkg::BIRTH_COUNT) ||
              (center && (count == lgs_pkg::SURVIVE_COUNT));
   end

endmodule

// File: src/lgs_row_window.sv
// ----------------------------------------------------------------------------
// Row window
// Holds the rows above, at and below the row being built, rotates them past
// the shared rule unit one column per cycle while advance is set, and collects the new row.
// ----------------------------------------------------------------------------
module lgs_row_window #(
   parameter int MAX_COLS = 128,
   parameter int LIM_CW   = 8
) (
   input  logic                  clock,
   input  lgs_pkg::win_ctrl_type ctrl,
   input  logic [MAX_COLS-1:0]   load_row,
   input  logic [LIM_CW-1:0]     cols_eff,
   output logic [MAX_COLS-1:0]   new_row
);

   logic [MAX_COLS-1:0] above_ff;
   logic [MAX_COLS-1:0] mid_ff;
   logic [MAX_COLS-1:0] below_ff;
   logic [2:0]          left_ff;
   logic [MAX_COLS-1:0] new_row_ff;
   logic [MAX_COLS-1:0] col_mask;
   logic [MAX_COLS-1:0] masked_row;
   logic [2:0]          right;
   logic                born;

   always_comb begin
      for (int i = 0; i < MAX_COLS; i++) begin
         col_mask[i] = (32'(i) < 32'(cols_eff));
      end
      masked_row = ctrl.load_live ? (load_row & col_mask) : '0;
      right = ctrl.col_last ? 3'b000 : {above_ff[1], mid_ff[1], below_ff[1]};
   end

   lgs_cell_rule u_rule (
      .center    (mid_ff[0]),
      .neighbors ({left_ff, above_ff[0], below_ff[0], right}),
      .alive     (born)
   );

   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         above_ff <= '0;
         mid_ff   <= '0;
         below_ff <= '0;
         left_ff  <= '0;
      end else if (ctrl.load) begin
         above_ff <= mid_ff;
         mid_ff   <= below_ff;
         below_ff <= masked_row;
         left_ff  <= '0;
      end else if (ctrl.advance) begin
         above_ff   <= {above_ff[0], above_ff[MAX_COLS-1:1]};
         mid_ff     <= {mid_ff[0], mid_ff[MAX_COLS-1:1]};
         below_ff   <= {below_ff[0], below_ff[MAX_COLS-1:1]};
         left_ff    <= {above_ff[0], mid_ff[0], below_ff[0]};
         new_row_ff <= {born & ctrl.keep, new_row_ff[MAX_COLS-1:1]};
      end
   end

   assign new_row = new_row_ff;

endmodule

// File: src/life_grid_stepper.sv
// ----------------------------------------------------------------------------
// Life grid stepper
// Cell grid with single-cell write and read and whole-grid B3/S23 generation
// steps, with the grid in use set by two configuration registers.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item: mode (write, read, step), row, col and cell_in.
//   rsp_* returns one transfer per item; rsp_cell_out is the cell for a read
//   and 0 otherwise. csr_* writes rows_in_use (index 0) or cols_in_use
//   (index 1); it is always ready. The user must see that it is written only
//   while the block idles; the block itself does not enforce this. Step: one
//   rule unit visits one cell per cycle as the row window rotates; each row
//   adds a fetch, a window load and a write-back on the row memory, which has
//   one write and one read port; the first row fetches two rows.
//   One item is in work at a time; req_ready is low until it finishes.
//   Reset clears the grid in a pass over all MAX_ROWS rows, one row per cycle,
//   with req_ready low; configuration returns to 100 rows and 100 columns.
//   A finished response waits in the output register while rsp_ready is low;
//   the next request is taken meanwhile, and its result holds until that
//   response transfers.
// ----------------------------------------------------------------------------
`include "life_grid_stepper_macros.svh"

module life_grid_stepper #(
   parameter int MAX_ROWS = 128,
   parameter int MAX_COLS = 128
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [lgs_pkg::MODE_W-1:0]     req_mode,
   input  logic [lgs_pkg::ROWF_W-1:0]     req_row,
   input  logic [lgs_pkg::COLF_W-1:0]     req_col,
   input  logic                           req_cell_in,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_cell_out,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lgs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lgs_pkg::CFG_W-1:0]      csr_data
);

   localparam int ROW_AW  = $clog2(MAX_ROWS);
   localparam int COL_AW  = $clog2(MAX_COLS);
   localparam int FETCH_W = $clog2(MAX_ROWS + 2);
   localparam int LIM_RW  = $clog2(MAX_ROWS + 1);
   localparam int LIM_CW  = $clog2(MAX_COLS + 1);

   lgs_pkg::state_type state_ff, state_in;

   logic [ROW_AW-1:0]             r_ff, r_in;
   logic [FETCH_W-1:0]            fetch_ff, fetch_in;
   logic [COL_AW-1:0]             c_ff, c_in;
   logic [lgs_pkg::MODE_W-1:0]    mode_ff;
   logic [lgs_pkg::ROWF_W-1:0]    row_ff;
   logic [lgs_pkg::COLF_W-1:0]    col_ff;
   logic                          cin_ff;
   logic                          res_ff, res_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_cell_out_ff, rsp_cell_out_in;
   logic [lgs_pkg::CFG_W-1:0]     rows_ff;
   logic [lgs_pkg::CFG_W-1:0]     cols_ff;

   logic [LIM_RW-1:0]   rows_eff;
   logic [LIM_CW-1:0]   cols_eff;
   logic                accept;
   logic                cell_inside;
   logic                row_active;
   logic                fetch_active;
   logic                col_active;
   logic                col_last;
   logic                rsp_free;
   logic [MAX_COLS-1:0] cell_row;

   logic                mem_we;
   logic [ROW_AW-1:0]   mem_waddr;
   logic [MAX_COLS-1:0] mem_wdata;
   logic                mem_re;
   logic [ROW_AW-1:0]   mem_raddr;
   logic [MAX_COLS-1:0] mem_rdata;

   lgs_pkg::win_ctrl_type win_ctrl;
   logic [MAX_COLS-1:0]   new_row;

   lgs_grid_mem #(
      .DEPTH (MAX_ROWS),
      .WIDTH (MAX_COLS)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   lgs_row_window #(
      .MAX_COLS (MAX_COLS),
      .LIM_CW   (LIM_CW)
   ) u_window (
      .clock    (clock),
      .ctrl     (win_ctrl),
      .load_row (mem_rdata),
      .cols_eff (cols_eff),
      .new_row  (new_row)
   );

   always_comb begin
      rows_eff = (32'(rows_ff) > MAX_ROWS) ? LIM_RW'(MAX_ROWS) : LIM_RW'(rows_ff);
      cols_eff = (32'(cols_ff) > MAX_COLS) ? LIM_CW'(MAX_COLS) : LIM_CW'(cols_ff);
      row_active   = (32'(r_ff) < 32'(rows_eff));
      fetch_active = (32'(fetch_ff) < 32'(rows_eff));
      col_active   = (32'(c_ff) < 32'(cols_eff));
      col_last     = (c_ff == COL_AW'(MAX_COLS - 1));
      cell_inside  = (32'(row_ff) < MAX_ROWS) && (32'(col_ff) < MAX_COLS);
      req_ready    = (state_ff == lgs_pkg::S_IDLE);
      accept       = req_valid && req_ready;
      rsp_free     = !rsp_valid_ff || rsp_ready;
      cell_row     = mem_rdata;
      if (cell_inside) begin
         cell_row[COL_AW'(col_ff)] = cin_ff;
      end
   end

   always_comb begin
      state_in        = state_ff;
      r_in            = r_ff;
      fetch_in        = fetch_ff;
      c_in            = c_ff;
      res_in          = res_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_cell_out_in = rsp_cell_out_ff;
      mem_we          = 1'b0;
      mem_waddr       = r_ff;
      mem_wdata       = '0;
      mem_re          = 1'b0;
      mem_raddr       = ROW_AW'(req_row);
      win_ctrl        = '0;

      unique case (state_ff)
         lgs_pkg::S_CLEAR: begin
            mem_we = 1'b1;
            if (r_ff == ROW_AW'(MAX_ROWS - 1)) begin
               r_in     = '0;
               state_in = lgs_pkg::S_IDLE;
            end else begin
               r_in = r_ff + ROW_AW'(1);
            end
         end
         lgs_pkg::S_IDLE: begin
            if (accept) begin
               unique case (req_mode) inside
                  lgs_pkg::MODE_WRITE, lgs_pkg::MODE_READ: begin
                     mem_re   = 1'b1;
                     state_in = lgs_pkg::S_CELL;
                  end
                  lgs_pkg::MODE_STEP: begin
                     r_in           = '0;
                     fetch_in       = '0;
                     win_ctrl.clear = 1'b1;
                     state_in       = lgs_pkg::S_FETCH;
                  end
                  default: begin
                     res_in   = 1'b0;
                     state_in = lgs_pkg::S_DONE;
                  end
               endcase
            end
         end
         lgs_pkg::S_CELL: begin
            mem_we    = (mode_ff == lgs_pkg::MODE_WRITE) && cell_inside;
            mem_waddr = ROW_AW'(row_ff);
            mem_wdata = cell_row;
            res_in    = (mode_ff == lgs_pkg::MODE_READ) && cell_inside &&
                        mem_rdata[COL_AW'(col_ff)];
            state_in  = lgs_pkg::S_DONE;
         end
         lgs_pkg::S_FETCH: begin
            mem_re    = (32'(fetch_ff) < MAX_ROWS);
            mem_raddr = ROW_AW'(fetch_ff);
            state_in  = lgs_pkg::S_SHIFT;
         end
         lgs_pkg::S_SHIFT: begin
            win_ctrl.load      = 1'b1;
            win_ctrl.load_live = fetch_active;
            fetch_in           = fetch_ff + FETCH_W'(1);
            if (fetch_ff == FETCH_W'(r_ff) + FETCH_W'(1)) begin
               c_in     = '0;
               state_in = lgs_pkg::S_COLS;
            end else begin
               state_in = lgs_pkg::S_FETCH;
            end
         end
         lgs_pkg::S_COLS: begin
            win_ctrl.advance  = 1'b1;
            win_ctrl.col_last = col_last;
            win_ctrl.keep     = col_active && row_active;
            c_in              = c_ff + COL_AW'(1);
            if (col_last) begin
               state_in = lgs_pkg::S_WRITE;
            end
         end
         lgs_pkg::S_WRITE: begin
            mem_we    = 1'b1;
            mem_wdata = new_row;
            if (r_ff == ROW_AW'(MAX_ROWS - 1)) begin
               res_in   = 1'b0;
               state_in = lgs_pkg::S_DONE;
            end else begin
               r_in     = r_ff + ROW_AW'(1);
               state_in = lgs_pkg::S_FETCH;
            end
         end
         lgs_pkg::S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in    = 1'b1;
               rsp_cell_out_in = res_ff;
               state_in        = lgs_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = lgs_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lgs_pkg::S_CLEAR;
         r_ff         <= '0;
         fetch_ff     <= '0;
         c_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         rows_ff      <= lgs_pkg::RESET_LIMIT;
         cols_ff      <= lgs_pkg::RESET_LIMIT;
      end else begin
         state_ff     <= state_in;
         r_ff         <= r_in;
         fetch_ff     <= fetch_in;
         c_ff         <= c_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               lgs_pkg::REG_ROWS: rows_ff <= csr_data;
               lgs_pkg::REG_COLS: cols_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_mode;
         row_ff  <= req_row;
         col_ff  <= req_col;
         cin_ff  <= req_cell_in;
      end
      res_ff          <= res_in;
      rsp_cell_out_ff <= rsp_cell_out_in;
   end

   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_cell_out = rsp_cell_out_ff;

   `LGS_ASSERT_IMPL(a_clear_blocks_req, clock, reset, state_ff == lgs_pkg::S_CLEAR, !req_ready, "request taken during clear pass")
   `LGS_ASSERT_IMPL(a_idle_no_write, clock, reset, state_ff == lgs_pkg::S_IDLE, !mem_we, "grid written while idle")
   `LGS_ASSERT_IMPL(a_window_ahead, clock, reset, state_ff == lgs_pkg::S_COLS, fetch_ff == FETCH_W'(r_ff) + FETCH_W'(2), "row window not aligned to row in work")
   `LGS_ASSERT_NEXT(a_row_written, clock, reset, (state_ff == lgs_pkg::S_COLS) && col_last, state_ff == lgs_pkg::S_WRITE, "row sweep did not end in write-back")
   `LGS_ASSERT_NEXT(a_result_loaded, clock, reset, (state_ff == lgs_pkg::S_DONE) && rsp_free, rsp_valid_ff && (state_ff == lgs_pkg::S_IDLE), "result not moved to response register")

endmodule

// File: bench/life_grid_stepper_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Life grid stepper checker
// Watches the request, response and register channels. It keeps its own copy
// of the cell grid and the grid size in use, and works out the expected
// cell_out of every accepted request, B3/S23 generations included. It then
// compares each response in order and hands the failure and pending counts to
// the bench top.
// ----------------------------------------------------------------------------
module life_grid_stepper_checker #(
   parameter int MAX_ROWS = 128,
   parameter int MAX_COLS = 128
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [lgs_pkg::MODE_W-1:0]     req_mode,
   input  logic [lgs_pkg::ROWF_W-1:0]     req_row,
   input  logic [lgs_pkg::COLF_W-1:0]     req_col,
   input  logic                           req_cell_in,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic                           rsp_cell_out,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [lgs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lgs_pkg::CFG_W-1:0]      csr_data,
   output int                             fail_count,
   output int                             pending_count
);

   typedef bit [MAX_COLS-1:0] grid_type [MAX_ROWS];

   grid_type                   grid;
   logic [lgs_pkg::CFG_W-1:0]  rows_limit;
   logic [lgs_pkg::CFG_W-1:0]  cols_limit;
   bit                         cell_out_q [$];
   bit                         expected_out;
   int                         mismatches;
   int                         rsp_seen;

   function automatic int live_neighbor(int r, int c, int nr, int nc);
      if (r < 0 || c < 0 || r >= nr || c >= nc) begin
         return 0;
      end
      return int'(grid[r][c]);
   endfunction

   function automatic void advance_generation();
      grid_type fresh;
      int       nr;
      int       nc;
      int       n;
      nr = (rows_limit > MAX_ROWS) ? MAX_ROWS : int'(rows_limit);
      nc = (cols_limit > MAX_COLS) ? MAX_COLS : int'(cols_limit);
      foreach (fresh[r]) begin
         fresh[r] = '0;
      end
      for (int r = 0; r < nr; r++) begin
         for (int c = 0; c < nc; c++) begin
            n = 0;
            for (int dr = -1; dr <= 1; dr++) begin
               for (int dc = -1; dc <= 1; dc++) begin
                  if (dr != 0 || dc != 0) begin
                     n += live_neighbor(r + dr, c + dc, nr, nc);
                  end
               end
            end
            if (grid[r][c]) begin
               fresh[r][c] = (n == lgs_pkg::SURVIVE_COUNT) || (n == lgs_pkg::BIRTH_COUNT);
            end else begin
               fresh[r][c] = (n == lgs_pkg::BIRTH_COUNT);
            end
         end
      end
      grid = fresh;
   endfunction

   function automatic bit run_grid_item(logic [lgs_pkg::MODE_W-1:0] mode,
                                        logic [lgs_pkg::ROWF_W-1:0] row,
                                        logic [lgs_pkg::COLF_W-1:0] col, logic value);
      bit in_store;
      in_store = (row < MAX_ROWS) && (col < MAX_COLS);
      case (mode)
         lgs_pkg::MODE_WRITE: begin
            if (in_store) begin
               grid[row][col] = value;
            end
         end
         lgs_pkg::MODE_READ: begin
            if (in_store) begin
               return grid[row][col];
            end
         end
         lgs_pkg::MODE_STEP: begin
            advance_generation();
         end
         default: begin
         end
      endcase
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (grid[r]) begin
            grid[r] = '0;
         end
         rows_limit = lgs_pkg::RESET_LIMIT;
         cols_limit = lgs_pkg::RESET_LIMIT;
         cell_out_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               lgs_pkg::REG_ROWS: begin
                  rows_limit = csr_data;
               end
               lgs_pkg::REG_COLS: begin
                  cols_limit = csr_data;
               end
               default: begin
               end
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            rsp_seen++;
            if (cell_out_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("response %0d with nothing expected, cell_out %0b",
                           rsp_seen, rsp_cell_out);
               end
            end else begin
               expected_out = cell_out_q.pop_front();
               if (expected_out !== rsp_cell_out) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("response %0d cell_out mismatch: expected %0b, got %0b",
                              rsp_seen, expected_out, rsp_cell_out);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            cell_out_q.push_back(run_grid_item(req_mode, req_row, req_col, req_cell_in));
         end
      end
      pending_count <= cell_out_q.size();
      fail_count    <= mismatches;
   end

endmodule

// File: bench/life_grid_stepper_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Life grid stepper testbench
// Drives cell writes, reads and generation steps with random gaps on both
// channels, over a series of grid sizes from empty to beyond the storage.
// Seeded patterns, near the edges of the grid in use or at random places, are
// stepped and read back. The checker predicts every response; this top gives the verdict.
// ----------------------------------------------------------------------------
module life_grid_stepper_tb;

   localparam int RESET_CYCLES = 9;
   localparam int STALL_LIMIT  = 100000;
   localparam int TAIL_CYCLES  = 32;
   localparam int LONG_HOLD    = 400;
   localparam int PHASES       = 8;
   localparam int GRID_LAST    = 127;

   localparam logic [lgs_pkg::MODE_W-1:0]    MODE_UNUSED  = 2'd3;
   localparam logic [lgs_pkg::CSR_IDX_W-1:0] REG_SPARE_LO = 2'd2;
   localparam logic [lgs_pkg::CSR_IDX_W-1:0] REG_SPARE_HI = 2'd3;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   logic [lgs_pkg::MODE_W-1:0]     req_mode;
   logic [lgs_pkg::ROWF_W-1:0]     req_row;
   logic [lgs_pkg::COLF_W-1:0]     req_col;
   logic                           req_cell_in;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic                           rsp_cell_out;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [lgs_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [lgs_pkg::CFG_W-1:0]      csr_data;

   int  fail_count;
   int  pending_results;
   int  rsp_hold_cycles;
   bit  req_eager;
   bit  rsp_eager;

   life_grid_stepper dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_mode     (req_mode),
      .req_row      (req_row),
      .req_col      (req_col),
      .req_cell_in  (req_cell_in),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_cell_out (rsp_cell_out),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   life_grid_stepper_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_cell_in   (req_cell_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_cell_out  (rsp_cell_out),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic send_item(input int mode, input int row, input int col, input int value);
      int gap;
      gap = req_eager ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_mode    <= lgs_pkg::MODE_W'(mode);
      req_row     <= lgs_pkg::ROWF_W'(row);
      req_col     <= lgs_pkg::COLF_W'(col);
      req_cell_in <= value[0];
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
   endtask

   task automatic csr_put(input logic [lgs_pkg::CSR_IDX_W-1:0] index,
                          input logic [lgs_pkg::CFG_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure_grid(input int rows, input int cols, input bit poke_spare);
      csr_put(lgs_pkg::REG_ROWS, lgs_pkg::CFG_W'(rows));
      csr_put(lgs_pkg::REG_COLS, lgs_pkg::CFG_W'(cols));
      if (poke_spare) begin
         csr_put($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                 lgs_pkg::CFG_W'($urandom));
      end
      csr_valid <= 1'b0;
   endtask

   function automatic int grid_index(int v);
      if (v < 0) begin
         return 0;
      end
      return (v > GRID_LAST) ? GRID_LAST : v;
   endfunction

   // seed a small window, step it, read the window and its rim
   task automatic play_pattern(input int live_rows, input int live_cols);
      int span;
      int r0;
      int c0;
      int pick;
      span = $urandom_range(3, 4);
      pick = $urandom_range(0, 2);
      r0 = (pick == 0) ? 0 : (pick == 1) ? live_rows - span : $urandom_range(0, 128 - span);
      pick = $urandom_range(0, 2);
      c0 = (pick == 0) ? 0 : (pick == 1) ? live_cols - span : $urandom_range(0, 128 - span);
      r0 = grid_index(r0) > 128 - span ? 128 - span : grid_index(r0);
      c0 = grid_index(c0) > 128 - span ? 128 - span : grid_index(c0);
      repeat ($urandom_range(4, 7)) begin
         send_item(lgs_pkg::MODE_WRITE, r0 + $urandom_range(0, span - 1),
                   c0 + $urandom_range(0, span - 1), $urandom_range(0, 9) < 7);
      end
      repeat (($urandom_range(0, 3) == 0) ? 2 : 1) begin
         send_item(lgs_pkg::MODE_STEP, $urandom_range(0, GRID_LAST),
                   $urandom_range(0, GRID_LAST), $urandom_range(0, 1));
      end
      repeat ($urandom_range(4, 6)) begin
         send_item(lgs_pkg::MODE_READ, grid_index(r0 - 1 + $urandom_range(0, span + 1)),
                   grid_index(c0 - 1 + $urandom_range(0, span + 1)), $urandom_range(0, 1));
      end
   endtask

   initial begin : response_side
      int gap;
      forever begin
         if (rsp_hold_cycles > 0) begin
            gap = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            gap = rsp_eager ? 0 : $urandom_range(0, 10);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
             || (csr_valid && csr_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      int rows_cfg;
      int cols_cfg;
      int pick;
      rsp_hold_cycles = 0;
      req_eager       = 1'b0;
      rsp_eager       = 1'b0;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_mode    <= lgs_pkg::MODE_WRITE;
      req_row     <= '0;
      req_col     <= '0;
      req_cell_in <= 1'b0;
      csr_valid   <= 1'b0;
      csr_index   <= lgs_pkg::REG_ROWS;
      csr_data    <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset grid is 100 x 100: corners, unused mode, edge blinker, corner block
      send_item(lgs_pkg::MODE_READ, 0, 0, 1);
      send_item(lgs_pkg::MODE_READ, GRID_LAST, GRID_LAST, 0);
      send_item(lgs_pkg::MODE_WRITE, GRID_LAST, GRID_LAST, 1);
      send_item(lgs_pkg::MODE_READ, GRID_LAST, GRID_LAST, 0);
      send_item(lgs_pkg::MODE_WRITE, 0, 0, 1);
      send_item(lgs_pkg::MODE_WRITE, 1, 0, 1);
      send_item(lgs_pkg::MODE_WRITE, 2, 0, 1);
      send_item(MODE_UNUSED, 1, 1, 1);
      send_item(lgs_pkg::MODE_READ, 1, 1, 0);
      send_item(lgs_pkg::MODE_WRITE, 98, 98, 1);
      send_item(lgs_pkg::MODE_WRITE, 98, 99, 1);
      send_item(lgs_pkg::MODE_WRITE, 99, 98, 1);
      send_item(lgs_pkg::MODE_WRITE, 99, 99, 1);
      send_item(lgs_pkg::MODE_WRITE, 99, 100, 1);
      send_item(lgs_pkg::MODE_WRITE, 64, 64, 1);
      send_item(lgs_pkg::MODE_WRITE, 64, 64, 0);
      send_item(lgs_pkg::MODE_STEP, 0, 0, 0);
      send_item(lgs_pkg::MODE_READ, 1, 0, 0);
      send_item(lgs_pkg::MODE_READ, 1, 1, 1);
      send_item(lgs_pkg::MODE_READ, 0, 0, 0);
      send_item(lgs_pkg::MODE_READ, 99, 99, 0);
      send_item(lgs_pkg::MODE_READ, 99, 100, 0);
      send_item(lgs_pkg::MODE_READ, GRID_LAST, GRID_LAST, 1);
      send_item(lgs_pkg::MODE_READ, 64, 64, 0);
      drain_results();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin rows_cfg = 128; cols_cfg = 128; end
            1: begin rows_cfg = 1;   cols_cfg = 1;   end
            2: begin rows_cfg = 0;   cols_cfg = 128; end
            3: begin rows_cfg = 255; cols_cfg = 255; end
            4: begin rows_cfg = 3;   cols_cfg = 5;   end
            6: begin rows_cfg = 128; cols_cfg = 0;   end
            7: begin
               rows_cfg = $urandom_range(4, 16);
               cols_cfg = $urandom_range(4, 16);
            end
            default: begin
               rows_cfg = $urandom_range(1, 128);
               cols_cfg = $urandom_range(1, 128);
            end
         endcase
         configure_grid(rows_cfg, cols_cfg, phase % 2 == 0);
         req_eager = (phase % 3 == 1);
         rsp_eager = (phase % 3 == 2);
         if (phase == 4) begin
            rsp_hold_cycles = LONG_HOLD;
         end
         play_pattern(rows_cfg > 128 ? 128 : rows_cfg, cols_cfg > 128 ? 128 : cols_cfg);
         repeat (2) begin
            pick = $urandom_range(0, 19);
            send_item(pick == 0 ? lgs_pkg::MODE_STEP : pick < 8 ? lgs_pkg::MODE_WRITE :
                      pick < 15 ? lgs_pkg::MODE_READ : MODE_UNUSED,
                      $urandom_range(0, GRID_LAST), $urandom_range(0, GRID_LAST),
                      $urandom_range(0, 1));
         end
         drain_results();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_results == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
